// File: rtl/core/erfa_pkg.sv
// Shared constants and types of the edge run-length frame assembler.
package erfa_pkg;

    // Block configuration
    localparam int MOTORS     = 4;
    localparam int FRAME_BITS = 21;

    // Field widths
    localparam int MOTOR_W    = 3;
    localparam int DELTA_W    = 16;
    localparam int OUT_W      = 21;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int REM_W      = DELTA_W + 1;
    localparam int S_TDATA_W  = ((MOTOR_W + DELTA_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((MOTOR_W + OUT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 1'b1;

    // Result status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    // Configuration seen by the core
    typedef struct packed {
        logic               enable;
        logic [DELTA_W-1:0] bit_period;
        logic               clear;
    } erfa_cfg_t;

    // Result handed from the core to the output register
    typedef struct packed {
        logic               valid;
        logic [MOTOR_W-1:0] motor;
        logic               status;
        logic [OUT_W-1:0]   word;
    } erfa_res_t;

endpackage

// File: rtl/core/erfa_sub_unit.sv
// Compare-and-subtract unit used by the rounding divide.
module erfa_sub_unit (
    input  logic [erfa_pkg::REM_W-1:0]   rem,
    input  logic [erfa_pkg::DELTA_W-1:0] divisor,
    output logic                         ge,
    output logic [erfa_pkg::REM_W-1:0]   diff
);
    import erfa_pkg::*;

    logic [REM_W:0] wide_diff;

    // One extra bit catches the borrow
    assign wide_diff = {1'b0, rem} - {2'b00, divisor};
    assign ge        = ~wide_diff[REM_W];
    assign diff      = wide_diff[REM_W-1:0];

endmodule

// File: rtl/core/erfa_frame_core.sv
// Sequencer and frame state: run rounding by repeated subtraction, bit shifting.
module erfa_frame_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  erfa_pkg::erfa_cfg_t          cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [erfa_pkg::MOTOR_W-1:0] in_motor,
    input  logic [erfa_pkg::DELTA_W-1:0] in_delta,
    input  logic                         in_last,
    input  logic                         out_free,
    output erfa_pkg::erfa_res_t          res
);
    import erfa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [FRAME_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  level_reg, level_next;
    logic                  done_reg, done_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  shifted_reg, shifted_next;
    logic [MOTOR_W-1:0]    motor_reg, motor_next;
    logic                  last_reg, last_next;
    logic [MOTOR_W-1:0]    res_motor_reg, res_motor_next;
    logic                  res_status_reg, res_status_next;
    logic [OUT_W-1:0]      res_word_reg, res_word_next;

    logic                  accept;
    logic                  motor_in_range;
    logic                  sub_ge;
    logic [REM_W-1:0]      sub_diff;
    logic                  has_room;
    logic [FRAME_BITS-1:0] word_shift;

    erfa_sub_unit u_sub (
        .rem     (rem_reg),
        .divisor (cfg.bit_period),
        .ge      (sub_ge),
        .diff    (sub_diff)
    );

    assign in_ready       = (state_reg == ST_IDLE);
    assign accept         = in_valid & in_ready;
    assign motor_in_range = ({1'b0, in_motor} < (MOTOR_W + 1)'(MOTORS));
    assign has_room       = (count_reg < CNT_W'(FRAME_BITS));
    assign word_shift     = {word_reg[FRAME_BITS-2:0], level_reg};

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        word_next       = word_reg;
        count_next      = count_reg;
        level_next      = level_reg;
        done_next       = done_reg;
        rem_next        = rem_reg;
        shifted_next    = shifted_reg;
        motor_next      = motor_reg;
        last_next       = last_reg;
        res_motor_next  = res_motor_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && cfg.enable && motor_in_range) begin
                    motor_next = in_motor;
                    last_next  = in_last;
                    if (done_reg) begin
                        // rest of an answered frame is dropped
                        if (in_last) begin
                            word_next  = '0;
                            count_next = '0;
                            level_next = 1'b0;
                            done_next  = 1'b0;
                        end
                    end else if (cfg.bit_period == '0) begin
                        res_motor_next  = in_motor;
                        res_status_next = STATUS_TIMEOUT;
                        res_word_next   = '0;
                        done_next       = 1'b1;
                        if (in_last) begin
                            word_next  = '0;
                            count_next = '0;
                            level_next = 1'b0;
                            done_next  = 1'b0;
                        end
                        state_next = ST_FIN;
                    end else begin
                        // rounding bias: delta + period/2
                        rem_next     = {1'b0, in_delta} +
                                       {2'b00, cfg.bit_period[DELTA_W-1:1]};
                        shifted_next = 1'b0;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (sub_ge && has_room) begin
                    rem_next     = sub_diff;
                    word_next    = word_shift;
                    count_next   = count_reg + 1'b1;
                    shifted_next = 1'b1;
                end else begin
                    // a run is always at least one bit
                    if (!shifted_reg) begin
                        word_next  = word_shift;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                level_next = ~level_reg;
                state_next = ST_IDLE;
                if (count_reg >= CNT_W'(FRAME_BITS)) begin
                    res_motor_next  = motor_reg;
                    res_status_next = STATUS_DONE;
                    res_word_next   = OUT_W'(word_reg);
                    done_next       = 1'b1;
                    state_next      = ST_FIN;
                end else if (last_reg) begin
                    res_motor_next  = motor_reg;
                    res_status_next = STATUS_TIMEOUT;
                    res_word_next   = '0;
                    state_next      = ST_FIN;
                end
                if (last_reg) begin
                    word_next  = '0;
                    count_next = '0;
                    level_next = 1'b0;
                    done_next  = 1'b0;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // disabling abandons the frame in progress
        if (cfg.clear) begin
            word_next  = '0;
            count_next = '0;
            level_next = 1'b0;
            done_next  = 1'b0;
        end
    end

    // Control and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            word_reg  <= '0;
            count_reg <= '0;
            level_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
            count_reg <= count_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        shifted_reg    <= shifted_next;
        motor_reg      <= motor_next;
        last_reg       <= last_next;
        res_motor_reg  <= res_motor_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
    end

    assign res.valid  = (state_reg == ST_FIN);
    assign res.motor  = res_motor_reg;
    assign res.status = res_status_reg;
    assign res.word   = res_word_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FRAME_BITS))
        else $error("bit count beyond frame length");

    a_fin_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (state_reg == ST_IDLE))
        else $error("result not released when output register is free");

    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.status == STATUS_TIMEOUT) |-> (res.word == '0))
        else $error("timeout result carries a nonzero word");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && !has_room) |=> (state_reg == ST_EVAL))
        else $error("run continued with a full frame");

endmodule

// File: rtl/core/edge_runlength_frame_assembler.sv
// Top level: stream ports, configuration registers and output register.
// Sequence: an accepted input transaction enters the subtract loop, which shifts in runs bits
//   (runs = rounded run length, capped by the bits left in the frame, at most FRAME_BITS),
//   then the evaluate state and, with a result, the result state; a zero period goes straight
//   to the result state. Input is taken only in idle; a result waits in the output register.
// Reset (aresetn low, synchronous) clears configuration, frame state and the output valid.
module edge_runlength_frame_assembler (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [erfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erfa_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [erfa_pkg::S_TDATA_W-1:0]  s_tdata,  // motor[2:0], delta[18:3], zero pad
    input  logic                            s_tlast,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [erfa_pkg::M_TDATA_W-1:0]  m_tdata,  // motor_tag[2:0], frame_word[23:3]
    output logic                            m_tuser   // status
);
    import erfa_pkg::*;

    logic                  enable_reg;
    logic [DELTA_W-1:0]    bit_period_reg;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic                  m_user_reg;
    logic                  out_free;
    erfa_cfg_t             cfg;
    erfa_res_t             res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            bit_period_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_BIT_PERIOD: bit_period_reg <= cfg_data[DELTA_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.enable     = enable_reg;
    assign cfg.bit_period = bit_period_reg;
    assign cfg.clear      = cfg_we && (cfg_index == REG_ENABLE) && !cfg_data[0];

    erfa_frame_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_motor (s_tdata[MOTOR_W-1:0]),
        .in_delta (s_tdata[MOTOR_W +: DELTA_W]),
        .in_last  (s_tlast),
        .out_free (out_free),
        .res      (res)
    );

    // Output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            m_data_reg <= M_TDATA_W'({res.word, res.motor});
            m_user_reg <= res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
